[rtl/core/wspd_pkg.sv]
// Shared types and constants for the wheel speed PID drive.
// No dependencies; imported by every module of the block.
package wspd_pkg;

  localparam int ACC_W     = 60;
  localparam int MULT_W    = 20;
  localparam int GAIN_W    = 20;
  localparam int DVD_W     = 37;
  localparam int DVS_W     = 20;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_PROP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV = 2'd2;

  localparam logic [GAIN_W-1:0] PROP_RST  = 20'd327680;
  localparam logic [GAIN_W-1:0] INTEG_RST = 20'd9830;
  localparam logic [GAIN_W-1:0] DERIV_RST = 20'd655;

  localparam logic [DVS_W-1:0] US_PER_S   = 20'd1000000;
  localparam logic [DVS_W-1:0] DECAY_DEN  = 20'd5;
  localparam logic [DVD_W-1:0] US_HALF    = 37'd500000;
  localparam logic [DVD_W-1:0] DECAY_HALF = 37'd2;

  typedef struct packed {
    logic signed [15:0] measured_speed;
    logic signed [15:0] target_speed;
    logic        [15:0] elapsed_us;
  } in_word_t;

  typedef struct packed {
    logic [7:0] duty;
    logic       bridge_a;
    logic       bridge_b;
  } out_word_t;

  typedef struct packed {
    logic start;
    logic acc_clr;
  } mul_req_t;

endpackage

[rtl/core/wspd_mul.sv]
// Serial shift-add multiplier: one multiplier bit per cycle into a signed accumulator.
// Depends on wspd_pkg.
module wspd_mul (
  input  logic                               clk,
  input  logic                               rst_n,
  input  wspd_pkg::mul_req_t                 req,
  input  logic signed [wspd_pkg::ACC_W-1:0]  mcand,
  input  logic        [wspd_pkg::MULT_W-1:0] mult,
  output logic                               busy,
  output logic signed [wspd_pkg::ACC_W-1:0]  acc
);
  import wspd_pkg::*;

  localparam int CNT_W = $clog2(MULT_W + 1);

  logic signed [ACC_W-1:0]  mcand_r, mcand_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic        [MULT_W-1:0] mult_r, mult_nxt;
  logic        [CNT_W-1:0]  cnt_r, cnt_nxt;

  always_comb begin
    mcand_nxt = mcand_r;
    acc_nxt   = acc_r;
    mult_nxt  = mult_r;
    cnt_nxt   = cnt_r;
    if (req.start) begin
      mcand_nxt = mcand;
      mult_nxt  = mult;
      cnt_nxt   = CNT_W'(MULT_W);
      if (req.acc_clr) begin
        acc_nxt = '0;
      end
    end else if (cnt_r != '0) begin
      if (mult_r[0]) begin
        acc_nxt = acc_r + mcand_r;
      end
      mcand_nxt = mcand_r <<< 1;
      mult_nxt  = mult_r >> 1;
      cnt_nxt   = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mcand_r <= mcand_nxt;
    acc_r   <= acc_nxt;
    mult_r  <= mult_nxt;
  end

  assign busy = (cnt_r != '0);
  assign acc  = acc_r;

endmodule

[rtl/core/wspd_div.sv]
// Serial restoring divider: one quotient bit per cycle, unsigned operands.
// Depends on wspd_pkg.
module wspd_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [wspd_pkg::DVD_W-1:0]  dvd,
  input  logic [wspd_pkg::DVS_W-1:0]  dvs,
  output logic                        busy,
  output logic [wspd_pkg::DVD_W-1:0]  quo
);
  import wspd_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] q_r, q_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   trial_sub;
  logic             ge;

  always_comb begin
    trial     = {rem_r, q_r[DVD_W-1]};
    trial_sub = trial - {1'b0, dvs_r};
    ge        = (trial >= {1'b0, dvs_r});
    q_nxt     = q_r;
    rem_nxt   = rem_r;
    dvs_nxt   = dvs_r;
    cnt_nxt   = cnt_r;
    if (start) begin
      q_nxt   = dvd;
      rem_nxt = '0;
      dvs_nxt = dvs;
      cnt_nxt = CNT_W'(DVD_W);
    end else if (cnt_r != '0) begin
      rem_nxt = ge ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
      q_nxt   = {q_r[DVD_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy = (cnt_r != '0);
  assign quo  = q_r;

endmodule

[rtl/core/wheel_speed_pid_deadband_drive_top.sv]
// Wheel speed PID with integral clamp and dead-band bridge drive; uses wspd_pkg,
// wspd_mul and wspd_div. Each word is processed by five 20-bit shift-add multiplies
// and two 37-bit restoring divides on the shared serial units; a new word is taken
// only once the previous result has been passed to the output register.
// Synchronous active-low reset: gains to defaults, integral and last error to zero.
module wheel_speed_pid_deadband_drive_top #(
  parameter int SPEED_FRAC_BITS = 12
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  wspd_pkg::in_word_t              in_word,
  output logic                            out_valid,
  input  logic                            out_ready,
  output wspd_pkg::out_word_t             out_word,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [wspd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wspd_pkg::GAIN_W-1:0]     cfg_data
);
  import wspd_pkg::*;

  localparam int IW   = SPEED_FRAC_BITS + 7;
  localparam int YM_W = SPEED_FRAC_BITS + 25;
  localparam logic signed [IW:0]     ILIM      = (IW+1)'(40 << SPEED_FRAC_BITS);
  localparam logic signed [IW:0]     ILIM_N    = -ILIM;
  localparam logic [15:0]            NEAR_ZERO = 16'((1 << SPEED_FRAC_BITS) / 1000);
  localparam logic [ACC_W-1:0]       SAT_LIM   = ACC_W'(1) << (17 + SPEED_FRAC_BITS);
  localparam logic [YM_W-1:0]        DEAD_LIM  = YM_W'(12) << (16 + SPEED_FRAC_BITS);
  localparam logic [YM_W:0]          RND_HALF  = (YM_W+1)'(1) << (15 + SPEED_FRAC_BITS);

  typedef enum logic [12:0] {
    S_IDLE  = 13'h0001,
    S_PREP  = 13'h0002,
    S_MUL1  = 13'h0004,
    S_DIV1  = 13'h0008,
    S_INTEG = 13'h0010,
    S_MUL2  = 13'h0020,
    S_DIV2  = 13'h0040,
    S_SUMP  = 13'h0080,
    S_SUMI  = 13'h0100,
    S_SUMD  = 13'h0200,
    S_SCALE = 13'h0400,
    S_ROUND = 13'h0800,
    S_DONE  = 13'h1000
  } state_t;

  state_t state_r, state_nxt;

  logic [GAIN_W-1:0] kp_r, kp_nxt, ki_r, ki_nxt, kd_r, kd_nxt;

  logic signed [16:0]    err_r, err_nxt;
  logic signed [16:0]    prev_r, prev_nxt;
  logic signed [17:0]    diff_r, diff_nxt;
  logic        [15:0]    dt_r, dt_nxt;
  logic                  decay_r, decay_nxt;
  logic                  dneg_r, dneg_nxt;
  logic signed [IW-1:0]  iacc_r, iacc_nxt;
  logic signed [37:0]    dval_r, dval_nxt;
  logic        [ACC_W-1:0] mag_r, mag_nxt;
  logic                  neg_r, neg_nxt;
  logic                  sat_r, sat_nxt;
  logic        [YM_W-1:0] ym_r, ym_nxt;
  out_word_t             res_r, res_nxt;
  out_word_t             out_word_r, out_word_nxt;
  logic                  out_valid_r, out_valid_nxt;

  mul_req_t                 mul_req;
  logic signed [ACC_W-1:0]  mul_mcand;
  logic        [MULT_W-1:0] mul_mult;
  logic                     mul_busy;
  logic signed [ACC_W-1:0]  mul_acc;
  logic                     div_start;
  logic        [DVD_W-1:0]  div_dvd;
  logic        [DVS_W-1:0]  div_dvs;
  logic                     div_busy;
  logic        [DVD_W-1:0]  div_quo;

  logic [15:0]           targ_u, targ_abs;
  logic [16:0]           err_abs;
  logic [17:0]           diff_abs;
  logic [IW-1:0]         iacc_abs;
  logic [IW:0]           q_mag;
  logic signed [IW:0]    q_sgn, i_base, i_sum, i_clamp;
  logic [37:0]           d_mag;
  logic [SPEED_FRAC_BITS+16:0] mag_lo;
  logic [YM_W:0]         rsum;
  logic [9:0]            pwm_raw;
  logic                  dead;

  wspd_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .mcand (mul_mcand),
    .mult  (mul_mult),
    .busy  (mul_busy),
    .acc   (mul_acc)
  );

  wspd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .dvd   (div_dvd),
    .dvs   (div_dvs),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  // configuration
  always_comb begin
    kp_nxt = kp_r;
    ki_nxt = ki_r;
    kd_nxt = kd_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_PROP:  kp_nxt = cfg_data;
        REG_INTEG: ki_nxt = cfg_data;
        REG_DERIV: kd_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  // operand conditioning
  always_comb begin
    targ_u   = in_word.target_speed;
    targ_abs = targ_u[15] ? (~targ_u + 16'd1) : targ_u;
    err_abs  = err_r[16] ? (~err_r + 17'd1) : err_r;
    diff_abs = diff_r[17] ? (~diff_r + 18'd1) : diff_r;
    iacc_abs = iacc_r[IW-1] ? (~iacc_r + 1'b1) : iacc_r;
    q_mag    = {1'b0, div_quo[IW-1:0]};
    q_sgn    = dneg_r ? (~q_mag + 1'b1) : q_mag;
    i_base   = decay_r ? '0 : {iacc_r[IW-1], iacc_r};
    i_sum    = i_base + q_sgn;
    if (i_sum > ILIM) begin
      i_clamp = ILIM;
    end else if (i_sum < ILIM_N) begin
      i_clamp = ILIM_N;
    end else begin
      i_clamp = i_sum;
    end
    d_mag   = {1'b0, div_quo};
    mag_lo  = mag_r[SPEED_FRAC_BITS+16:0];
    rsum    = {1'b0, ym_r} + RND_HALF;
    pwm_raw = rsum[YM_W:16+SPEED_FRAC_BITS];
    dead    = !sat_r && (ym_r < DEAD_LIM);
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    err_nxt       = err_r;
    prev_nxt      = prev_r;
    diff_nxt      = diff_r;
    dt_nxt        = dt_r;
    decay_nxt     = decay_r;
    dneg_nxt      = dneg_r;
    iacc_nxt      = iacc_r;
    dval_nxt      = dval_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    sat_nxt       = sat_r;
    ym_nxt        = ym_r;
    res_nxt       = res_r;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r && !out_ready;
    mul_req       = '0;
    mul_mcand     = '0;
    mul_mult      = '0;
    div_start     = 1'b0;
    div_dvd       = '0;
    div_dvs       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          err_nxt   = {in_word.target_speed[15], in_word.target_speed}
                    - {in_word.measured_speed[15], in_word.measured_speed};
          dt_nxt    = (in_word.elapsed_us == 16'd0) ? 16'd1 : in_word.elapsed_us;
          decay_nxt = (targ_abs <= NEAR_ZERO);
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        diff_nxt        = {err_r[16], err_r} - {prev_r[16], prev_r};
        prev_nxt        = err_r;
        mul_req.start   = 1'b1;
        mul_req.acc_clr = 1'b1;
        mul_mcand       = {{(ACC_W-17){1'b0}}, err_abs};
        mul_mult        = {{(MULT_W-16){1'b0}}, dt_r};
        state_nxt       = S_MUL1;
      end
      S_MUL1: begin
        if (!mul_busy) begin
          div_start = 1'b1;
          if (decay_r) begin
            div_dvd  = {{(DVD_W-IW-2){1'b0}}, iacc_abs, 2'b00} + DECAY_HALF;
            div_dvs  = DECAY_DEN;
            dneg_nxt = iacc_r[IW-1];
          end else begin
            div_dvd  = mul_acc[DVD_W-1:0] + US_HALF;
            div_dvs  = US_PER_S;
            dneg_nxt = err_r[16];
          end
          state_nxt = S_DIV1;
        end
      end
      S_DIV1: begin
        if (!div_busy) begin
          state_nxt = S_INTEG;
        end
      end
      S_INTEG: begin
        iacc_nxt        = i_clamp[IW-1:0];
        mul_req.start   = 1'b1;
        mul_req.acc_clr = 1'b1;
        mul_mcand       = {{(ACC_W-18){1'b0}}, diff_abs};
        mul_mult        = US_PER_S;
        state_nxt       = S_MUL2;
      end
      S_MUL2: begin
        if (!mul_busy) begin
          div_start = 1'b1;
          div_dvd   = mul_acc[DVD_W-1:0] + {{(DVD_W-15){1'b0}}, dt_r[15:1]};
          div_dvs   = {{(DVS_W-16){1'b0}}, dt_r};
          dneg_nxt  = diff_r[17];
          state_nxt = S_DIV2;
        end
      end
      S_DIV2: begin
        if (!div_busy) begin
          dval_nxt        = dneg_r ? (~d_mag + 38'd1) : d_mag;
          mul_req.start   = 1'b1;
          mul_req.acc_clr = 1'b1;
          mul_mcand       = {{(ACC_W-17){err_r[16]}}, err_r};
          mul_mult        = kp_r;
          state_nxt       = S_SUMP;
        end
      end
      S_SUMP: begin
        if (!mul_busy) begin
          mul_req.start = 1'b1;
          mul_mcand     = {{(ACC_W-IW){iacc_r[IW-1]}}, iacc_r};
          mul_mult      = ki_r;
          state_nxt     = S_SUMI;
        end
      end
      S_SUMI: begin
        if (!mul_busy) begin
          mul_req.start = 1'b1;
          mul_mcand     = {{(ACC_W-38){dval_r[37]}}, dval_r};
          mul_mult      = kd_r;
          state_nxt     = S_SUMD;
        end
      end
      S_SUMD: begin
        if (!mul_busy) begin
          neg_nxt   = mul_acc[ACC_W-1];
          mag_nxt   = mul_acc[ACC_W-1] ? (~mul_acc + 1'b1) : mul_acc;
          state_nxt = S_SCALE;
        end
      end
      S_SCALE: begin
        sat_nxt   = (mag_r >= SAT_LIM);
        ym_nxt    = {mag_lo, 8'd0} - {8'd0, mag_lo};
        state_nxt = S_ROUND;
      end
      S_ROUND: begin
        if (dead) begin
          res_nxt = '0;
        end else begin
          res_nxt.duty     = (sat_r || (pwm_raw > 10'd255)) ? 8'd255 : pwm_raw[7:0];
          res_nxt.bridge_a = neg_r;
          res_nxt.bridge_b = !neg_r;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_word_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      kp_r        <= PROP_RST;
      ki_r        <= INTEG_RST;
      kd_r        <= DERIV_RST;
      prev_r      <= '0;
      iacc_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      kp_r        <= kp_nxt;
      ki_r        <= ki_nxt;
      kd_r        <= kd_nxt;
      prev_r      <= prev_nxt;
      iacc_r      <= iacc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    err_r      <= err_nxt;
    diff_r     <= diff_nxt;
    dt_r       <= dt_nxt;
    decay_r    <= decay_nxt;
    dneg_r     <= dneg_nxt;
    dval_r     <= dval_nxt;
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    sat_r      <= sat_nxt;
    ym_r       <= ym_nxt;
    res_r      <= res_nxt;
    out_word_r <= out_word_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign cfg_ready = 1'b1;

endmodule
